// ===== design/pkb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkb_pkg
// Shared constants, types and command/status structs of the update batcher.
// ----------------------------------------------------------------------------
package pkb_pkg;

	localparam int NODE_COUNT  = 1024;
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int BUCKET_CAP  = 16;
	localparam int SLOT_W      = (BUCKET_CAP > 1) ? $clog2(BUCKET_CAP) : 1;
	localparam int CNT_W       = $clog2(BUCKET_CAP + 1);
	localparam int NB_W        = 32;
	localparam int LIMIT_W     = 5;
	localparam int STORE_DEPTH = NODE_COUNT * BUCKET_CAP;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_FLUSH  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_READ,
		ST_LOAD,
		ST_HOLD
	} pkb_state_t;

	typedef struct packed {
		logic clr_step;
		logic load_item;
		logic lookup;
		logic rd_first;
		logic rd_next;
		logic load_out;
	} pkb_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic emit;
		logic out_last;
	} pkb_status_t;

endpackage

// ===== design/pkb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkb_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module pkb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/pkb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkb_ctrl
// Controller state machine: clearing pass, item lookup and batch emission.
// ----------------------------------------------------------------------------
module pkb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  pkb_pkg::pkb_status_t st,
	output pkb_pkg::pkb_cmd_t    cmd
);

	import pkb_pkg::*;

	pkb_state_t state_q;
	pkb_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = st.emit ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				cmd.rd_first = 1'b1;
				state_d      = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_out = 1'b1;
				state_d      = ST_HOLD;
			end
			ST_HOLD: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (st.out_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
						state_d     = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== design/pkb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkb_datapath
// Bucket counts, bucket storage, item and output registers of the batcher.
// ----------------------------------------------------------------------------
module pkb_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pkb_pkg::pkb_cmd_t                   cmd,
	output pkb_pkg::pkb_status_t                st,
	input  logic                                cfg_wr_en,
	input  logic [pkb_pkg::LIMIT_W-1:0]         cfg_wr_data,
	input  logic                                func,
	input  logic [pkb_pkg::NODE_W-1:0]          node,
	input  logic [pkb_pkg::NB_W-1:0]            neighbor,
	output logic [pkb_pkg::NODE_W-1:0]          node_key,
	output logic [pkb_pkg::NB_W-1:0]            neighbor_out,
	output logic                                last
);

	import pkb_pkg::*;

	logic [LIMIT_W-1:0] batch_limit_q;
	logic [NODE_W-1:0]  clr_addr_q;
	logic               func_q;
	logic [NODE_W-1:0]  node_q;
	logic [NB_W-1:0]    nb_q;
	logic [CNT_W-1:0]   n_q;
	logic [SLOT_W-1:0]  k_q;
	logic [NODE_W-1:0]  node_key_q;
	logic [NB_W-1:0]    neighbor_q;
	logic               last_q;

	logic [CNT_W-1:0]   cnt_rdata;
	logic [CNT_W-1:0]   cnt_new;
	logic [CNT_W-1:0]   lim_eff;
	logic               full;
	logic               emit;
	logic [CNT_W-1:0]   emit_n;
	logic [CNT_W-1:0]   cnt_wval;
	logic               store_we;
	logic               cnt_we;
	logic [NODE_W-1:0]  cnt_waddr;
	logic [CNT_W-1:0]   cnt_wdata;
	logic [SLOT_W-1:0]  rd_slot;
	logic [NB_W-1:0]    store_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_limit_q <= LIMIT_RESET;
			clr_addr_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				batch_limit_q <= cfg_wr_data;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// A zero limit acts as one, a limit above the capacity as the capacity.
	always_comb begin
		if (batch_limit_q == '0) begin
			lim_eff = CNT_W'(1);
		end else if ({1'b0, batch_limit_q} > (LIMIT_W + 1)'(BUCKET_CAP)) begin
			lim_eff = CNT_W'(BUCKET_CAP);
		end else begin
			lim_eff = CNT_W'(batch_limit_q);
		end
	end

	always_comb begin
		full     = cnt_rdata >= CNT_W'(BUCKET_CAP);
		cnt_new  = cnt_rdata + 1'b1;
		store_we = 1'b0;
		emit     = 1'b0;
		emit_n   = cnt_rdata;
		cnt_wval = '0;
		if (func_q == FUNC_FLUSH) begin
			emit = cnt_rdata != '0;
		end else if (full) begin
			emit = 1'b1;
		end else begin
			store_we = 1'b1;
			if (cnt_new >= lim_eff) begin
				emit   = 1'b1;
				emit_n = cnt_new;
			end else begin
				cnt_wval = cnt_new;
			end
		end
	end

	assign cnt_we    = cmd.clr_step || cmd.lookup;
	assign cnt_waddr = cmd.clr_step ? clr_addr_q : node_q;
	assign cnt_wdata = cmd.clr_step ? '0 : cnt_wval;

	pkb_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NODE_COUNT)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cmd.load_item),
		.raddr (node),
		.rdata (cnt_rdata)
	);

	assign rd_slot = cmd.rd_next ? k_q + 1'b1 : '0;

	pkb_ram #(
		.WIDTH (NB_W),
		.DEPTH (STORE_DEPTH)
	) u_store_ram (
		.clk   (clk),
		.we    (cmd.lookup && store_we),
		.waddr ({node_q, cnt_rdata[SLOT_W-1:0]}),
		.wdata (nb_q),
		.re    (cmd.rd_first || cmd.rd_next),
		.raddr ({node_q, rd_slot}),
		.rdata (store_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= func;
			node_q <= node;
			nb_q   <= neighbor;
		end
		if (cmd.lookup) begin
			n_q <= emit_n;
		end
		if (cmd.rd_first || cmd.rd_next) begin
			k_q <= rd_slot;
		end
		if (cmd.load_out) begin
			node_key_q <= node_q;
			neighbor_q <= store_rdata;
			last_q     <= (CNT_W'(k_q) + 1'b1) == n_q;
		end
	end

	assign st.clr_done = clr_addr_q == NODE_W'(NODE_COUNT - 1);
	assign st.emit     = emit;
	assign st.out_last = last_q;

	assign node_key     = node_key_q;
	assign neighbor_out = neighbor_q;
	assign last         = last_q;

endmodule

// ===== design/per_key_update_batcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_update_batcher
// Collects neighbor updates into per-node buckets and emits them as batches.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024 bucket counts, one per cycle, and
// holds in_stall high while it does so. An item then passes through a count
// read and then an update when it emits nothing. When a batch is emitted,
// the read of the bucket store is started first; each element is then moved
// from the registered read data of the bucket store into the output register
// and then transferred from the output register, and further items wait
// until the last element of the batch has been transferred. The batch limit
// may be written only while the block is idle.
module per_key_update_batcher (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pkb_pkg::LIMIT_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [pkb_pkg::NODE_W-1:0]   node,
	input  logic [pkb_pkg::NB_W-1:0]     neighbor,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pkb_pkg::NODE_W-1:0]   node_key,
	output logic [pkb_pkg::NB_W-1:0]     neighbor_out,
	output logic                         last
);

	import pkb_pkg::*;

	pkb_cmd_t    cmd;
	pkb_status_t st;

	pkb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	pkb_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.func         (func),
		.node         (node),
		.neighbor     (neighbor),
		.node_key     (node_key),
		.neighbor_out (neighbor_out),
		.last         (last)
	);

endmodule
